// ===== src/mpec_pkg.sv =====
`default_nettype none
package mpec_pkg;

    // Sizing limits
    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_POOL     = 16;
    localparam int HEIGHT_LIMIT = 4096;

    localparam int COL_W  = $clog2(MAX_WIDTH);     // column position, window column
    localparam int ROW_W  = $clog2(HEIGHT_LIMIT);  // row position, band row
    localparam int WIN_W  = $clog2(MAX_POOL);      // position inside a window
    localparam int POOL_W = 5;
    localparam int IW_W   = 11;
    localparam int IH_W   = 13;
    localparam int OROW_W = 13;
    localparam int OCOL_W = 11;
    localparam int PX_W   = 32;                    // value, red, green, blue packed
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 56;
    localparam int NRES   = 4;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    localparam logic [POOL_W-1:0] POOL_RST   = 5'd2;
    localparam logic [IW_W-1:0]   WIDTH_RST  = 11'd640;
    localparam logic [IH_W-1:0]   HEIGHT_RST = 13'd480;

    // Result slot order inside one transaction run
    localparam int SLOT_BAND   = 0;
    localparam int SLOT_XCOL   = 1;
    localparam int SLOT_XROW   = 2;
    localparam int SLOT_CORNER = 3;

    typedef struct packed {
        logic band_load;
        logic band_emit;
        logic xc_en;
        logic xc_load;
        logic xc_emit;
        logic xr_en;
        logic xr_load;
        logic xr_emit;
        logic cn_emit;
    } job_flags_t;

    typedef struct packed {
        logic [PX_W-1:0]  px;
        logic [ROW_W-1:0] band_row;
        logic [COL_W-1:0] win_col;
        job_flags_t       flags;
    } job_t;

    typedef struct packed {
        logic [PX_W-1:0]   acc;
        logic [OROW_W-1:0] row;
        logic [OCOL_W-1:0] col;
    } result_t;

    // Keep acc unless loading or the new gray value is strictly larger.
    function automatic logic [PX_W-1:0] merge(input logic [PX_W-1:0] acc,
                                              input logic [PX_W-1:0] px,
                                              input logic            load);
        logic [PX_W-1:0] r;
        r = acc;
        if (load || (px[31:24] > acc[31:24])) begin
            r = px;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/max_pool_edge_clamped_rgb.sv =====
// Channel   Dir  Handshake            Payload
// s_        in   s_tvalid/s_tready    s_tdata: pixel_value, red, green, blue
// m_        out  m_tvalid/m_tready    m_tdata: pooled value/rgb, out_row, out_col;
//                                     m_tlast: last_of_run
// cfg_      in   cfg_valid/cfg_ready  cfg_index, cfg_data (pool_size, width, height)
//
// Sustained rate is one pixel per clock while m_tready is high and every pixel
// causes at most one result. Each pixel causes up to four results and the result
// port moves one per clock; the 4-entry job queue absorbs short bursts of those.
// m_tvalid rises once the pixel has passed the job queue, the band RAM read and
// the merge into the result register; a stalled result port can delay it.
// aresetn is synchronous; it clears control state and the extra accumulators.
// The band RAM is not cleared and needs no clearing pass. Either side can stall
// independently: s_tready only depends on queue fill.
`default_nettype none
module max_pool_edge_clamped_rgb (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // pixel in
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [7:0] pixel_value, [15:8] red, [23:16] green, [31:24] blue
    input  wire logic [mpec_pkg::IN_TDATA_W-1:0]   s_tdata,
    // result out
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [7:0] pooled_value, [15:8] pooled_red, [23:16] pooled_green,
    // [31:24] pooled_blue, [44:32] out_row, [55:45] out_col
    output logic [mpec_pkg::OUT_TDATA_W-1:0]       m_tdata,
    output logic                                   m_tlast,   // last_of_run
    // configuration writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [mpec_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mpec_pkg::CFG_DATA_W-1:0]   cfg_data
);

    mpec_pkg::job_t push_job, head_job;
    logic           push, q_full, q_valid, q_pop;

    // front: counters, window position, per-pixel job classification
    mpec_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push),
        .job       (push_job)
    );

    // decouples pixel intake from result delivery
    mpec_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .head      (head_job)
    );

    // back: band RAM read-modify-write, extra accumulators, result serializer
    mpec_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_head    (head_job),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
`default_nettype wire

// ===== src/mpec_front.sv =====
`default_nettype none
module mpec_front (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [mpec_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [mpec_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mpec_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                               q_full,
    output logic                                    push,
    output mpec_pkg::job_t                          job
);

    logic [mpec_pkg::POOL_W-1:0] pool_reg,   pool_next;
    logic [mpec_pkg::IW_W-1:0]   width_reg,  width_next;
    logic [mpec_pkg::IH_W-1:0]   height_reg, height_next;

    logic [mpec_pkg::COL_W-1:0]  col_pos_reg,  col_pos_next;
    logic [mpec_pkg::ROW_W-1:0]  row_pos_reg,  row_pos_next;
    logic [mpec_pkg::WIN_W-1:0]  ciw_reg,      ciw_next;
    logic [mpec_pkg::WIN_W-1:0]  riw_reg,      riw_next;
    logic [mpec_pkg::COL_W-1:0]  win_col_reg,  win_col_next;
    logic [mpec_pkg::ROW_W-1:0]  band_row_reg, band_row_next;

    logic cfg_we, restart;
    logic last_col, last_row, wrap_c, wrap_r, end_c, end_r, quiet;
    logic [mpec_pkg::POOL_W-1:0] pool_in;
    logic [mpec_pkg::IW_W-1:0]   width_in;
    logic [mpec_pkg::IH_W-1:0]   height_in;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign push      = s_tvalid && !q_full;
    assign cfg_we    = cfg_valid && cfg_ready;

    // clamp incoming register values to their legal ranges
    always_comb begin
        pool_in   = cfg_data[mpec_pkg::POOL_W-1:0];
        width_in  = cfg_data[mpec_pkg::IW_W-1:0];
        height_in = cfg_data[mpec_pkg::IH_W-1:0];
        if (pool_in == '0) begin
            pool_in = mpec_pkg::POOL_W'(1);
        end else if (pool_in > mpec_pkg::POOL_W'(mpec_pkg::MAX_POOL)) begin
            pool_in = mpec_pkg::POOL_W'(mpec_pkg::MAX_POOL);
        end
        if (width_in == '0) begin
            width_in = mpec_pkg::IW_W'(1);
        end else if (width_in > mpec_pkg::IW_W'(mpec_pkg::MAX_WIDTH)) begin
            width_in = mpec_pkg::IW_W'(mpec_pkg::MAX_WIDTH);
        end
        if (height_in == '0) begin
            height_in = mpec_pkg::IH_W'(1);
        end else if (height_in > mpec_pkg::IH_W'(mpec_pkg::HEIGHT_LIMIT)) begin
            height_in = mpec_pkg::IH_W'(mpec_pkg::HEIGHT_LIMIT);
        end
    end

    always_comb begin
        pool_next   = pool_reg;
        width_next  = width_reg;
        height_next = height_reg;
        restart     = 1'b0;
        if (cfg_we) begin
            unique case (cfg_index)
                mpec_pkg::CFG_POOL_SIZE: begin
                    pool_next = pool_in;
                    restart   = 1'b1;
                end
                mpec_pkg::CFG_IMAGE_WIDTH: begin
                    width_next = width_in;
                    restart    = 1'b1;
                end
                mpec_pkg::CFG_IMAGE_HEIGHT: begin
                    height_next = height_in;
                    restart     = 1'b1;
                end
                default: begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    // classification
    assign last_col = ({1'b0, col_pos_reg} + 11'd1) >= width_reg;
    assign last_row = ({1'b0, row_pos_reg} + 13'd1) >= height_reg;
    assign wrap_c   = ({1'b0, ciw_reg} + 5'd1) >= pool_reg;
    assign wrap_r   = ({1'b0, riw_reg} + 5'd1) >= pool_reg;
    assign end_c    = wrap_c || last_col;
    assign end_r    = wrap_r || last_row;
    // output dimension under 3 means size < 2 * pool
    assign quiet    = (width_reg < {5'b0, pool_reg, 1'b0})
                   || (height_reg < {7'b0, pool_reg, 1'b0});

    always_comb begin
        job.px       = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]};
        job.band_row = band_row_reg;
        job.win_col  = win_col_reg;
        job.flags.band_load = (ciw_reg == '0) && (riw_reg == '0);
        job.flags.band_emit = end_c && end_r && !quiet;
        // last column closing a full window: width is a multiple of pool
        job.flags.xc_en     = last_col && wrap_c;
        job.flags.xc_load   = (riw_reg == '0);
        job.flags.xc_emit   = last_col && wrap_c && end_r && !quiet;
        job.flags.xr_en     = last_row && wrap_r;
        job.flags.xr_load   = (ciw_reg == '0);
        job.flags.xr_emit   = last_row && wrap_r && end_c && !quiet;
        job.flags.cn_emit   = last_col && wrap_c && last_row && wrap_r && !quiet;
    end

    always_comb begin
        col_pos_next  = col_pos_reg;
        row_pos_next  = row_pos_reg;
        ciw_next      = ciw_reg;
        riw_next      = riw_reg;
        win_col_next  = win_col_reg;
        band_row_next = band_row_reg;
        if (restart) begin
            col_pos_next  = '0;
            row_pos_next  = '0;
            ciw_next      = '0;
            riw_next      = '0;
            win_col_next  = '0;
            band_row_next = '0;
        end else if (push) begin
            if (last_col) begin
                col_pos_next = '0;
                ciw_next     = '0;
                win_col_next = '0;
                if (last_row) begin
                    row_pos_next  = '0;
                    riw_next      = '0;
                    band_row_next = '0;
                end else begin
                    row_pos_next = row_pos_reg + 1'b1;
                    if (wrap_r) begin
                        riw_next      = '0;
                        band_row_next = band_row_reg + 1'b1;
                    end else begin
                        riw_next = riw_reg + 1'b1;
                    end
                end
            end else begin
                col_pos_next = col_pos_reg + 1'b1;
                if (wrap_c) begin
                    ciw_next     = '0;
                    win_col_next = win_col_reg + 1'b1;
                end else begin
                    ciw_next = ciw_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_reg     <= mpec_pkg::POOL_RST;
            width_reg    <= mpec_pkg::WIDTH_RST;
            height_reg   <= mpec_pkg::HEIGHT_RST;
            col_pos_reg  <= '0;
            row_pos_reg  <= '0;
            ciw_reg      <= '0;
            riw_reg      <= '0;
            win_col_reg  <= '0;
            band_row_reg <= '0;
        end else begin
            pool_reg     <= pool_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            col_pos_reg  <= col_pos_next;
            row_pos_reg  <= row_pos_next;
            ciw_reg      <= ciw_next;
            riw_reg      <= riw_next;
            win_col_reg  <= win_col_next;
            band_row_reg <= band_row_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/mpec_queue.sv =====
`default_nettype none
module mpec_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire mpec_pkg::job_t push_data,
    output logic                full,
    input  wire logic           pop,
    output logic                q_valid,
    output mpec_pkg::job_t      head
);

    mpec_pkg::job_t               entry_reg [mpec_pkg::QDEPTH];
    logic [mpec_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [mpec_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [mpec_pkg::QPTR_W:0]    count_reg,  count_next;
    logic                         do_push, do_pop;

    assign full    = (count_reg == (mpec_pkg::QPTR_W+1)'(mpec_pkg::QDEPTH));
    assign q_valid = (count_reg != '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/mpec_back.sv =====
`default_nettype none
module mpec_back (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              q_valid,
    input  wire mpec_pkg::job_t                    q_head,
    output logic                                   q_pop,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [mpec_pkg::OUT_TDATA_W-1:0]       m_tdata,
    output logic                                   m_tlast
);

    // band accumulators, one per window column; no reset, every entry is
    // loaded by the first pixel of its window before it is read
    logic [mpec_pkg::PX_W-1:0] band_mem [mpec_pkg::MAX_WIDTH];

    logic                      b2_valid_reg, b2_valid_next;
    mpec_pkg::job_t            b2_job_reg;
    logic [mpec_pkg::PX_W-1:0] rdata_reg;
    logic                      byp_hit_reg;
    logic [mpec_pkg::PX_W-1:0] byp_data_reg;
    logic [mpec_pkg::PX_W-1:0] xc_acc_reg, xc_acc_next;
    logic [mpec_pkg::PX_W-1:0] xr_acc_reg, xr_acc_next;

    logic [mpec_pkg::NRES-1:0] b3_mask_reg, b3_mask_next;
    mpec_pkg::result_t         b3_res_reg [mpec_pkg::NRES];

    logic [mpec_pkg::PX_W-1:0] band_base, band_new, xc_new, xr_new;
    logic [mpec_pkg::NRES-1:0] sel_oh, b3_rest, new_mask;
    logic                      b3_free, b2_adv;
    logic [mpec_pkg::OROW_W-1:0] row_here, row_below;
    logic [mpec_pkg::OCOL_W-1:0] col_here, col_right;
    mpec_pkg::result_t         sel_res;

    // ---- merge stage ----
    assign band_base = byp_hit_reg ? byp_data_reg : rdata_reg;
    assign band_new  = mpec_pkg::merge(band_base, b2_job_reg.px, b2_job_reg.flags.band_load);
    assign xc_new    = b2_job_reg.flags.xc_en
                     ? mpec_pkg::merge(xc_acc_reg, b2_job_reg.px, b2_job_reg.flags.xc_load)
                     : xc_acc_reg;
    assign xr_new    = b2_job_reg.flags.xr_en
                     ? mpec_pkg::merge(xr_acc_reg, b2_job_reg.px, b2_job_reg.flags.xr_load)
                     : xr_acc_reg;

    assign row_here  = {1'b0, b2_job_reg.band_row};
    assign row_below = row_here + 1'b1;
    assign col_here  = {1'b0, b2_job_reg.win_col};
    assign col_right = col_here + 1'b1;

    always_comb begin
        new_mask = '0;
        new_mask[mpec_pkg::SLOT_BAND]   = b2_job_reg.flags.band_emit;
        new_mask[mpec_pkg::SLOT_XCOL]   = b2_job_reg.flags.xc_emit;
        new_mask[mpec_pkg::SLOT_XROW]   = b2_job_reg.flags.xr_emit;
        new_mask[mpec_pkg::SLOT_CORNER] = b2_job_reg.flags.cn_emit;
    end

    // ---- result stage: lowest pending slot goes out first ----
    assign sel_oh   = b3_mask_reg & (~b3_mask_reg + 1'b1);
    assign b3_rest  = b3_mask_reg & ~sel_oh;
    assign m_tvalid = (b3_mask_reg != '0);
    assign m_tlast  = (b3_rest == '0);
    assign b3_free  = (b3_mask_reg == '0) || (m_tready && (b3_rest == '0));
    assign b2_adv   = b2_valid_reg && b3_free;
    assign q_pop    = q_valid && (!b2_valid_reg || b2_adv);

    always_comb begin
        sel_res = '0;
        for (int i = 0; i < mpec_pkg::NRES; i++) begin
            if (sel_oh[i]) begin
                sel_res = sel_res | b3_res_reg[i];
            end
        end
    end

    assign m_tdata = {sel_res.col, sel_res.row, sel_res.acc[7:0], sel_res.acc[15:8],
                      sel_res.acc[23:16], sel_res.acc[31:24]};

    always_comb begin
        b2_valid_next = b2_valid_reg;
        if (q_pop) begin
            b2_valid_next = 1'b1;
        end else if (b2_adv) begin
            b2_valid_next = 1'b0;
        end
        b3_mask_next = b3_mask_reg;
        if (b2_adv) begin
            b3_mask_next = new_mask;
        end else if (m_tvalid && m_tready) begin
            b3_mask_next = b3_rest;
        end
        xc_acc_next = b2_adv ? xc_new : xc_acc_reg;
        xr_acc_next = b2_adv ? xr_new : xr_acc_reg;
    end

    // memory ports
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            rdata_reg <= band_mem[q_head.win_col];
        end
    end

    always_ff @(posedge aclk) begin
        if (b2_adv) begin
            band_mem[b2_job_reg.win_col] <= band_new;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            b2_job_reg <= q_head;
            // write landing on the same edge as the read is missed by the RAM
            byp_hit_reg  <= b2_adv && (b2_job_reg.win_col == q_head.win_col);
            byp_data_reg <= band_new;
        end
        if (b2_adv) begin
            b3_res_reg[mpec_pkg::SLOT_BAND]   <= '{acc: band_new, row: row_here,
                                                   col: col_here};
            b3_res_reg[mpec_pkg::SLOT_XCOL]   <= '{acc: xc_new, row: row_here,
                                                   col: col_right};
            b3_res_reg[mpec_pkg::SLOT_XROW]   <= '{acc: xr_new, row: row_below,
                                                   col: col_here};
            b3_res_reg[mpec_pkg::SLOT_CORNER] <= '{acc: b2_job_reg.px, row: row_below,
                                                   col: col_right};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b2_valid_reg <= 1'b0;
            b3_mask_reg  <= '0;
            xc_acc_reg   <= '0;
            xr_acc_reg   <= '0;
        end else begin
            b2_valid_reg <= b2_valid_next;
            b3_mask_reg  <= b3_mask_next;
            xc_acc_reg   <= xc_acc_next;
            xr_acc_reg   <= xr_acc_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/mpec_checker.sv =====
`default_nettype none
module mpec_checker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [mpec_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  wire logic                              m_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // a run of results is delivered without gaps
    a_run_cont: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("result run broken before its last transaction");

    // output coordinates stay inside the largest grid
    a_coord_rng: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[55:45] <= 11'd1024) && (m_tdata[44:32] <= 13'd4096))
        else $error("output coordinate out of range");

    // nothing pending right after reset
    a_rst_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind max_pool_edge_clamped_rgb mpec_checker u_checker (.*);
`default_nettype wire
